@@ rtl/first_fit_aligned_region_allocator_macros.svh @@
// Assertion macros shared by the region allocator RTL.
// Depends on nothing; users must have signals named clk and arst_n in scope.
`ifndef FIRST_FIT_ALIGNED_REGION_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_ALIGNED_REGION_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS
// Checks a property on every rising clock edge outside of reset.
`define FFARA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);
// Checks that a condition never holds outside of reset.
`define FFARA_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);
`else
`define FFARA_ASSERT(lbl, prop, msg)
`define FFARA_NEVER(lbl, cond, msg)
`endif

`endif

@@ rtl/ffara_pkg.sv @@
// Types, codes and constants of the first-fit aligned region allocator.
// Used by every module of the block but ffara_ram; depends on nothing.
package ffara_pkg;

	localparam int ADDR_BITS       = 32;
	localparam int OWNER_BITS      = 8;
	localparam int MAX_REGIONS_DEF = 16;
	// The end of a region needs one more bit, its rounded-up end two more.
	localparam int END_BITS        = ADDR_BITS + 1;
	localparam int LAST_BITS       = ADDR_BITS + 2;

	typedef enum logic {
		KIND_ALLOC = 1'b0,
		KIND_FREE  = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_NO_SPACE  = 2'd1,
		STAT_FULL      = 2'd2,
		STAT_NOT_FOUND = 2'd3
	} status_t;

	typedef struct packed {
		kind_t                 kind;
		logic [OWNER_BITS-1:0] owner_id;
		logic [ADDR_BITS-1:0]  req_length;
		logic [ADDR_BITS-1:0]  req_align;
	} req_t;

	typedef struct packed {
		status_t              status;
		logic [ADDR_BITS-1:0] region_offset;
	} rsp_t;

	typedef struct packed {
		logic [ADDR_BITS-1:0]  start;
		logic [ADDR_BITS-1:0]  length;
		logic [OWNER_BITS-1:0] owner;
	} entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ALLOC_SCAN,
		S_ALLOC_MOD,
		S_SHIFT_UP,
		S_WRITE_NEW,
		S_FREE_SCAN,
		S_SHIFT_DOWN
	} state_t;

	typedef enum logic [2:0] {
		IDX_HOLD,
		IDX_INC,
		IDX_DEC,
		IDX_CLEAR,
		IDX_LAST
	} idx_op_t;

	typedef enum logic [1:0] {
		WR_NONE,
		WR_UP,
		WR_DOWN,
		WR_NEW
	} wr_op_t;

	typedef enum logic [1:0] {
		CNT_HOLD,
		CNT_INC,
		CNT_DEC
	} cnt_op_t;

	typedef struct packed {
		logic    load_req;
		idx_op_t idx_op;
		logic    step_end;
		logic    rem_start;
		logic    rem_apply;
		logic    save_pos;
		logic    save_offset;
		wr_op_t  wr_op;
		cnt_op_t cnt_op;
		logic    respond;
		status_t rsp_status;
	} dp_cmd_t;

	typedef struct packed {
		logic at_count;
		logic at_pos;
		logic full;
		logic gap_fit;
		logic tail_fit;
		logic pow2;
		logic owner_hit;
		logic rem_done;
	} dp_sts_t;

endpackage

@@ rtl/ffara_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module ffara_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/ffara_rem.sv @@
// Bit-serial remainder unit: one dividend bit per cycle, restoring form.
// Depends on ffara_pkg and the assertion macro header.
`include "first_fit_aligned_region_allocator_macros.svh"

module ffara_rem
	import ffara_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [END_BITS-1:0]  dividend,
	input  logic [ADDR_BITS-1:0] divisor,
	output logic                 done,
	output logic [ADDR_BITS-1:0] rem
);

	localparam int CntW = $clog2(END_BITS + 1);

	logic                 busy_q;
	logic                 done_q;
	logic [CntW-1:0]      cnt_q;
	logic [END_BITS-1:0]  dvd_q;
	logic [ADDR_BITS-1:0] div_q;
	logic [ADDR_BITS-1:0] rem_q;
	logic [ADDR_BITS:0]   trial;
	logic [ADDR_BITS:0]   diff;
	logic                 ge;

	assign trial = {rem_q, dvd_q[END_BITS-1]};
	assign ge    = trial >= {1'b0, div_q};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(END_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CntW'(1);
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			// A trial below the divisor is below 2^ADDR_BITS, so the drop is safe.
			rem_q <= ge ? diff[ADDR_BITS-1:0] : trial[ADDR_BITS-1:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

	`FFARA_ASSERT(a_rem_below_div, done_q |-> (rem_q < div_q), "remainder not below divisor")
	`FFARA_NEVER(a_start_while_busy, start && busy_q, "remainder unit restarted mid-run")

endmodule

@@ rtl/ffara_dp.sv @@
// Datapath of the region allocator: region table, request and scan registers,
// gap and tail tests, alignment rounding, result register.
// Depends on ffara_pkg, ffara_ram, ffara_rem and the assertion macro header.
`include "first_fit_aligned_region_allocator_macros.svh"

module ffara_dp
	import ffara_pkg::*;
#(
	parameter int MAX_REGIONS = MAX_REGIONS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dp_cmd_t              cmd,
	output dp_sts_t              sts,
	input  req_t                 req,
	input  logic                 cfg_write,
	input  logic [ADDR_BITS-1:0] cfg_data,
	output logic                 done,
	output rsp_t                 rsp
);

	localparam int IdxW  = $clog2(MAX_REGIONS + 1);
	localparam int AddrW = $clog2(MAX_REGIONS);

	// Configuration and table occupancy.
	logic [ADDR_BITS-1:0] pool_q;
	logic [IdxW-1:0]      count_q;
	logic [IdxW-1:0]      idx_q;
	logic [IdxW-1:0]      idx_d;
	logic [IdxW-1:0]      pos_q;

	// Latched request.
	kind_t                 kind_q;
	logic [OWNER_BITS-1:0] owner_q;
	logic [ADDR_BITS-1:0]  len_q;
	logic [ADDR_BITS-1:0]  align_q;
	logic [ADDR_BITS-1:0]  mask_q;
	logic                  pow2_q;

	// Scan state.
	logic [LAST_BITS-1:0] last_end_q;
	logic [END_BITS-1:0]  end_q;
	logic [ADDR_BITS-1:0] offset_q;

	logic                 done_q;
	rsp_t                 rsp_q;

	logic [ADDR_BITS-1:0] align_eff;
	logic [ADDR_BITS-1:0] mask_eff;
	entry_t               rd_entry;
	logic [$bits(entry_t)-1:0] ram_rdata;
	entry_t               wr_entry;
	logic                 ram_we;
	logic [IdxW-1:0]      wr_idx;
	logic [LAST_BITS:0]   need;
	logic [END_BITS-1:0]  end_sum;
	logic [LAST_BITS-1:0] rnd_pow2;
	logic [LAST_BITS-1:0] rnd_rem;
	logic [ADDR_BITS-1:0] rem_val;
	logic                 rem_done;
	logic [ADDR_BITS-1:0] offset_out;

	assign align_eff = (req.req_align == '0) ? ADDR_BITS'(1) : req.req_align;
	assign mask_eff  = align_eff - ADDR_BITS'(1);

	assign rd_entry = entry_t'(ram_rdata);

	// A zero-length request fits anywhere, so it never depends on the sums below.
	assign need    = {1'b0, last_end_q} + (LAST_BITS + 1)'(len_q);
	assign end_sum = END_BITS'(rd_entry.start) + END_BITS'(rd_entry.length);
	assign rnd_pow2 = (LAST_BITS'(end_sum) + LAST_BITS'(mask_q)) & ~LAST_BITS'(mask_q);
	assign rnd_rem  = (rem_val == '0) ? LAST_BITS'(end_q)
		: LAST_BITS'(end_q) + LAST_BITS'(align_q) - LAST_BITS'(rem_val);

	always_comb begin
		sts           = '0;
		sts.at_count  = idx_q == count_q;
		sts.at_pos    = idx_q == pos_q;
		sts.full      = count_q == IdxW'(MAX_REGIONS);
		sts.gap_fit   = (len_q == '0) || ((LAST_BITS + 1)'(rd_entry.start) >= need);
		sts.tail_fit  = (len_q == '0) || ((LAST_BITS + 1)'(pool_q) >= need);
		sts.pow2      = pow2_q;
		sts.owner_hit = rd_entry.owner == owner_q;
		sts.rem_done  = rem_done;
	end

	always_comb begin
		unique case (cmd.idx_op)
			IDX_HOLD:  idx_d = idx_q;
			IDX_INC:   idx_d = idx_q + IdxW'(1);
			IDX_DEC:   idx_d = idx_q - IdxW'(1);
			IDX_CLEAR: idx_d = '0;
			IDX_LAST:  idx_d = count_q - IdxW'(1);
			default:   idx_d = idx_q;
		endcase
	end

	always_comb begin
		wr_entry.start  = last_end_q[ADDR_BITS-1:0];
		wr_entry.length = len_q;
		wr_entry.owner  = owner_q;
		unique case (cmd.wr_op)
			WR_NONE: wr_idx = idx_q;
			WR_UP:   wr_idx = idx_q + IdxW'(1);
			WR_DOWN: wr_idx = idx_q - IdxW'(1);
			WR_NEW:  wr_idx = pos_q;
		endcase
		if (cmd.wr_op != WR_NEW) begin
			wr_entry = rd_entry;
		end
	end

	assign ram_we = cmd.wr_op != WR_NONE;

	ffara_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (MAX_REGIONS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_idx[AddrW-1:0]),
		.wdata (wr_entry),
		.raddr (idx_d[AddrW-1:0]),
		.rdata (ram_rdata)
	);

	ffara_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.rem_start),
		.dividend (end_sum),
		.divisor  (align_q),
		.done     (rem_done),
		.rem      (rem_val)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_q  <= '0;
			count_q <= '0;
			idx_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			if (cfg_write) begin
				pool_q <= cfg_data;
			end
			idx_q  <= idx_d;
			done_q <= cmd.respond;
			unique case (cmd.cnt_op)
				CNT_HOLD: count_q <= count_q;
				CNT_INC:  count_q <= count_q + IdxW'(1);
				CNT_DEC:  count_q <= count_q - IdxW'(1);
				default:  count_q <= count_q;
			endcase
		end
	end

	// An allocation reports its placement, a free the start of the removed region.
	assign offset_out = (kind_q == KIND_ALLOC) ? last_end_q[ADDR_BITS-1:0] : offset_q;

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			kind_q  <= req.kind;
			owner_q <= req.owner_id;
			len_q   <= req.req_length;
			align_q <= align_eff;
			mask_q  <= mask_eff;
			pow2_q  <= (align_eff & mask_eff) == '0;
		end
		priority if (cmd.load_req) begin
			last_end_q <= '0;
		end else if (cmd.step_end) begin
			last_end_q <= rnd_pow2;
		end else if (cmd.rem_apply) begin
			last_end_q <= rnd_rem;
		end else begin
			last_end_q <= last_end_q;
		end
		if (cmd.rem_start) begin
			end_q <= end_sum;
		end
		if (cmd.save_pos) begin
			pos_q <= idx_q;
		end
		if (cmd.save_offset) begin
			offset_q <= rd_entry.start;
		end
		if (cmd.respond) begin
			rsp_q.status        <= cmd.rsp_status;
			rsp_q.region_offset <= (cmd.rsp_status == STAT_OK) ? offset_out : '0;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	`FFARA_ASSERT(a_count_bound, count_q <= IdxW'(MAX_REGIONS), "region count past table size")
	`FFARA_ASSERT(a_write_in_table, ram_we |-> (wr_idx <= count_q),
		"table write beyond the occupied entries")

endmodule

@@ rtl/ffara_ctrl.sv @@
// Controller of the region allocator: sequences the scan, the table shift and
// the result. Depends on ffara_pkg and the assertion macro header.
`include "first_fit_aligned_region_allocator_macros.svh"

module ffara_ctrl
	import ffara_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  kind_t   kind,
	input  dp_sts_t sts,
	output dp_cmd_t cmd,
	output logic    busy
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					if (kind == KIND_FREE) begin
						state_d = S_FREE_SCAN;
					end else if (!sts.full) begin
						state_d = S_ALLOC_SCAN;
					end
				end
			end
			S_ALLOC_SCAN: begin
				priority if (sts.at_count) begin
					state_d = sts.tail_fit ? S_WRITE_NEW : S_IDLE;
				end else if (sts.gap_fit) begin
					state_d = S_SHIFT_UP;
				end else if (!sts.pow2) begin
					state_d = S_ALLOC_MOD;
				end else begin
					state_d = S_ALLOC_SCAN;
				end
			end
			S_ALLOC_MOD: begin
				if (sts.rem_done) begin
					state_d = S_ALLOC_SCAN;
				end
			end
			S_SHIFT_UP: begin
				if (sts.at_pos) begin
					state_d = S_WRITE_NEW;
				end
			end
			S_WRITE_NEW: state_d = S_IDLE;
			S_FREE_SCAN: begin
				priority if (sts.at_count) begin
					state_d = S_IDLE;
				end else if (sts.owner_hit) begin
					state_d = S_SHIFT_DOWN;
				end else begin
					state_d = S_FREE_SCAN;
				end
			end
			S_SHIFT_DOWN: begin
				if (sts.at_count) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd            = '0;
		cmd.idx_op     = IDX_HOLD;
		cmd.wr_op      = WR_NONE;
		cmd.cnt_op     = CNT_HOLD;
		cmd.rsp_status = STAT_OK;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					if (kind == KIND_ALLOC && sts.full) begin
						cmd.respond    = 1'b1;
						cmd.rsp_status = STAT_FULL;
					end else begin
						cmd.load_req = 1'b1;
						cmd.idx_op   = IDX_CLEAR;
					end
				end
			end
			S_ALLOC_SCAN: begin
				priority if (sts.at_count) begin
					if (sts.tail_fit) begin
						cmd.save_pos = 1'b1;
					end else begin
						cmd.respond    = 1'b1;
						cmd.rsp_status = STAT_NO_SPACE;
					end
				end else if (sts.gap_fit) begin
					// Move the entries from the top down to open the slot.
					cmd.save_pos = 1'b1;
					cmd.idx_op   = IDX_LAST;
				end else if (sts.pow2) begin
					cmd.step_end = 1'b1;
					cmd.idx_op   = IDX_INC;
				end else begin
					cmd.rem_start = 1'b1;
				end
			end
			S_ALLOC_MOD: begin
				if (sts.rem_done) begin
					cmd.rem_apply = 1'b1;
					cmd.idx_op    = IDX_INC;
				end
			end
			S_SHIFT_UP: begin
				cmd.wr_op = WR_UP;
				if (!sts.at_pos) begin
					cmd.idx_op = IDX_DEC;
				end
			end
			S_WRITE_NEW: begin
				cmd.wr_op   = WR_NEW;
				cmd.cnt_op  = CNT_INC;
				cmd.respond = 1'b1;
			end
			S_FREE_SCAN: begin
				priority if (sts.at_count) begin
					cmd.respond    = 1'b1;
					cmd.rsp_status = STAT_NOT_FOUND;
				end else if (sts.owner_hit) begin
					cmd.save_offset = 1'b1;
					cmd.idx_op      = IDX_INC;
				end else begin
					cmd.idx_op = IDX_INC;
				end
			end
			S_SHIFT_DOWN: begin
				if (sts.at_count) begin
					cmd.cnt_op  = CNT_DEC;
					cmd.respond = 1'b1;
				end else begin
					cmd.wr_op  = WR_DOWN;
					cmd.idx_op = IDX_INC;
				end
			end
			default: begin
				cmd.idx_op = IDX_HOLD;
			end
		endcase
	end

	assign busy = state_q != S_IDLE;

	`FFARA_ASSERT(a_rsp_ends_item, cmd.respond |=> (state_q == S_IDLE),
		"result issued without the item ending")
	`FFARA_ASSERT(a_scan_not_full, (state_q == S_ALLOC_SCAN) |-> !sts.full,
		"allocation scan with a full table")

endmodule

@@ rtl/first_fit_aligned_region_allocator.sv @@
// First-fit aligned region allocator, top level.
// Depends on ffara_pkg, ffara_ctrl and ffara_dp.
//
// Usage: an item (req) is taken at a rising edge with start high and busy low.
// kind selects allocate or free. Allocate scans the address-ordered region
// table, placing the region in the first gap that fits after the previous
// region end rounded up to req_align, or after the last region if the pool
// still has room. Free removes the first region of owner_id.
// The result (rsp) is shown for exactly one cycle with done high; the
// receiver cannot stall, so it must take it in that cycle.
// pool_size is written through cfg_valid/cfg_ready/cfg_data while busy is low.
// With n occupied entries, a refused allocate on a full table answers from idle. A
// power-of-two allocate passes entries, makes the tail or gap decision, moves entries
// up, writes the new entry and loads the result register; passed and moved entries
// add up to n. With any other alignment, each entry passed also waits for the
// bit-serial remainder unit. A free scans for the owner and, on a hit, moves the
// later entries down. The single table RAM port pair sets the one-entry-per-cycle
// shift and, between remainder waits, scan. A new item is taken once busy drops.
// Reset empties the table and clears pool_size; no clearing pass is needed.
module first_fit_aligned_region_allocator
	import ffara_pkg::*;
#(
	parameter int MAX_REGIONS = MAX_REGIONS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  req_t                 req,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [ADDR_BITS-1:0] cfg_data,
	output logic                 done,
	output rsp_t                 rsp
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	assign cfg_ready = !busy;

	ffara_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (req.kind),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	ffara_dp #(
		.MAX_REGIONS (MAX_REGIONS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.req       (req),
		.cfg_write (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.done      (done),
		.rsp       (rsp)
	);

endmodule

@@ tb/region_alloc_checker.sv @@
`timescale 1ns / 100ps
// Checker for the first-fit aligned region allocator: watches the request, pool write
// and result channels, keeps its own copy of the region table and compares results.
// Depends on ffara_pkg for the request, result, kind and status types.
module region_alloc_checker
	import ffara_pkg::*;
#(
	parameter int TABLE_DEPTH = MAX_REGIONS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 busy,
	input  req_t                 req,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [ADDR_BITS-1:0] cfg_data,
	input  logic                 done,
	input  rsp_t                 rsp,
	output int                   pending,
	output int                   errors
);

	logic [ADDR_BITS-1:0]  pool_bytes;
	logic [ADDR_BITS-1:0]  tbl_start [TABLE_DEPTH];
	logic [ADDR_BITS-1:0]  tbl_len [TABLE_DEPTH];
	logic [OWNER_BITS-1:0] tbl_owner [TABLE_DEPTH];
	int                    n_regions;
	rsp_t                  awaited_replies [$];

	function automatic logic [63:0] round_to(input logic [63:0] v, input logic [63:0] a);
		logic [63:0] rem;
		rem = v % a;
		return (rem == 64'd0) ? v : v + (a - rem);
	endfunction

	// Applies one request to the local table and returns the result it must give.
	function automatic rsp_t predict_reply(input req_t r);
		rsp_t        res;
		logic [63:0] step, prev_end, gap, room, len, s, e;
		int          slot;
		int          i;
		bit          found;
		res.status = STAT_OK;
		res.region_offset = '0;
		found = 1'b0;
		slot = n_regions;
		if (r.kind == KIND_FREE) begin
			for (i = 0; i < n_regions; i++) begin
				if (!found && tbl_owner[i] == r.owner_id) begin
					found = 1'b1;
					slot = i;
				end
			end
			if (!found) begin
				res.status = STAT_NOT_FOUND;
			end else begin
				res.region_offset = tbl_start[slot];
				for (i = slot; i + 1 < n_regions; i++) begin
					tbl_start[i] = tbl_start[i + 1];
					tbl_len[i] = tbl_len[i + 1];
					tbl_owner[i] = tbl_owner[i + 1];
				end
				n_regions--;
			end
		end else if (n_regions >= TABLE_DEPTH) begin
			res.status = STAT_FULL;
		end else begin
			step = (r.req_align == '0) ? 64'd1 : 64'(r.req_align);
			len = 64'(r.req_length);
			prev_end = 64'd0;
			for (i = 0; i < n_regions; i++) begin
				if (!found) begin
					s = 64'(tbl_start[i]);
					e = s + 64'(tbl_len[i]);
					// A rounded end beyond the next start leaves no gap at all.
					gap = (s >= prev_end) ? s - prev_end : 64'd0;
					if (gap >= len) begin
						found = 1'b1;
						slot = i;
					end else begin
						prev_end = round_to(e, step);
					end
				end
			end
			room = (64'(pool_bytes) >= prev_end) ? 64'(pool_bytes) - prev_end : 64'd0;
			if (!found && room < len) begin
				res.status = STAT_NO_SPACE;
			end else begin
				for (i = n_regions; i > slot; i--) begin
					tbl_start[i] = tbl_start[i - 1];
					tbl_len[i] = tbl_len[i - 1];
					tbl_owner[i] = tbl_owner[i - 1];
				end
				tbl_start[slot] = prev_end[ADDR_BITS-1:0];
				tbl_len[slot] = r.req_length;
				tbl_owner[slot] = r.owner_id;
				n_regions++;
				res.region_offset = prev_end[ADDR_BITS-1:0];
			end
		end
		return res;
	endfunction

	always @(posedge clk) begin : watch
		rsp_t want;
		int   bad;
		bad = 0;
		if (!arst_n) begin
			pool_bytes = '0;
			n_regions = 0;
			awaited_replies.delete();
			errors <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				pool_bytes = cfg_data;
			end
			// A result leaves before a new item enters, since both can share one edge.
			if (done) begin
				if (awaited_replies.size() == 0) begin
					$error("result with no item waiting: status %0d region_offset %h",
						rsp.status, rsp.region_offset);
					bad++;
				end else begin
					want = awaited_replies.pop_front();
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp.status);
						bad++;
					end
					if (rsp.region_offset !== want.region_offset) begin
						$error("region_offset: expected %h, got %h",
							want.region_offset, rsp.region_offset);
						bad++;
					end
				end
			end
			if (start && !busy) begin
				awaited_replies.push_back(predict_reply(req));
			end
			errors <= errors + bad;
		end
		pending <= awaited_replies.size();
	end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// Top of the region allocator testbench: clock, reset, request and pool size stimulus.
// Depends on ffara_pkg, first_fit_aligned_region_allocator and region_alloc_checker.
module tb;
	import ffara_pkg::*;

	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 135;
	localparam int CYCLE_LIMIT = 4000000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	req_t                 req = '0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [ADDR_BITS-1:0] cfg_data = '0;
	logic                 done;
	rsp_t                 rsp;
	int                   pending;
	int                   errors;
	int                   cycles = 0;

	always #5 clk = ~clk;

	first_fit_aligned_region_allocator u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.done(done),
		.rsp(rsp)
	);

	region_alloc_checker u_check (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.done(done),
		.rsp(rsp),
		.pending(pending),
		.errors(errors)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic req_t build_req(input kind_t k, input logic [OWNER_BITS-1:0] o,
		input logic [ADDR_BITS-1:0] l, input logic [ADDR_BITS-1:0] a);
		req_t r;
		r.kind = k;
		r.owner_id = o;
		r.req_length = l;
		r.req_align = a;
		return r;
	endfunction

	// Called at a rising edge; start stays high afterwards so a back-to-back item
	// needs no second assignment in the same step.
	task automatic issue(input req_t r, input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy);
	endtask

	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic write_pool(input logic [ADDR_BITS-1:0] v);
		drain();
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [ADDR_BITS-1:0] pool_now, span;
		int                   alloc_pct, burst_left, gap, pick, ph, n, i;
		req_t                 r;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Pool size still zero from reset: only a zero-byte region fits.
		issue(build_req(KIND_ALLOC, 8'd0, 32'd0, 32'd1), $urandom_range(9));
		issue(build_req(KIND_ALLOC, 8'd1, 32'd1, 32'd1), $urandom_range(9));
		issue(build_req(KIND_FREE, 8'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF), $urandom_range(9));
		issue(build_req(KIND_FREE, 8'd0, 32'd0, 32'd0), $urandom_range(9));

		write_pool(32'hFFFF_FFFF);
		// Whole pool with zero alignment, then nothing left after it.
		issue(build_req(KIND_ALLOC, 8'd255, 32'hFFFF_FFFF, 32'd0), $urandom_range(9));
		issue(build_req(KIND_ALLOC, 8'd1, 32'd1, 32'd1), $urandom_range(9));
		issue(build_req(KIND_FREE, 8'd255, 32'd0, 32'd0), $urandom_range(9));
		issue(build_req(KIND_ALLOC, 8'd1, 32'd100, 32'd1), $urandom_range(9));
		issue(build_req(KIND_ALLOC, 8'd2, 32'd10, 32'h8000_0000), $urandom_range(9));
		issue(build_req(KIND_ALLOC, 8'd3, 32'd7, 32'd3), $urandom_range(9));
		// Rounded end lands beyond the pool end.
		issue(build_req(KIND_ALLOC, 8'd4, 32'hFFFF_FFFF, 32'h8000_0000), $urandom_range(9));
		issue(build_req(KIND_FREE, 8'd1, 32'd0, 32'd0), $urandom_range(9));
		issue(build_req(KIND_ALLOC, 8'd5, 32'd100, 32'd1), $urandom_range(9));
		issue(build_req(KIND_ALLOC, 8'd6, 32'd1, 32'h4000_0000), $urandom_range(9));
		issue(build_req(KIND_ALLOC, 8'd7, 32'd1, 32'd1), $urandom_range(9));
		// The first region's rounded end passes the start of the second one.
		issue(build_req(KIND_ALLOC, 8'd8, 32'd1, 32'h4000_0000), $urandom_range(9));
		for (i = 0; i < 10; i++) begin
			issue(build_req(KIND_ALLOC, 8'(16 + i), 32'd0, 32'd1), $urandom_range(9));
		end
		issue(build_req(KIND_ALLOC, 8'd9, 32'd1, 32'd1), $urandom_range(9));

		burst_left = 0;
		for (ph = 0; ph < PHASES; ph++) begin
			unique case (ph)
				0: pool_now = 32'd4096;
				1, 5: pool_now = $urandom_range(65536, 256);
				2: pool_now = '0;
				3, 6: pool_now = $urandom();
				default: pool_now = 32'hFFFF_FFFF;
			endcase
			write_pool(pool_now);
			alloc_pct = (ph % 2 == 0) ? 80 : 40;
			span = (pool_now >> 4) + 1;
			for (n = 0; n < PHASE_ITEMS; n++) begin
				r.kind = ($urandom_range(99) < alloc_pct) ? KIND_ALLOC : KIND_FREE;
				r.owner_id = ($urandom_range(99) < 85) ? OWNER_BITS'($urandom_range(15))
					: OWNER_BITS'($urandom_range(255));
				pick = $urandom_range(99);
				if (pick < 70)
					r.req_length = $urandom_range(span);
				else if (pick < 80)
					r.req_length = '0;
				else
					r.req_length = $urandom();
				pick = $urandom_range(99);
				if (pick < 75)
					r.req_align = 32'd1 << $urandom_range(12);
				else if (pick < 85)
					r.req_align = 32'd1 << $urandom_range(31);
				else if (pick < 95)
					r.req_align = $urandom();
				else
					r.req_align = '0;
				if (burst_left > 0) begin
					burst_left--;
					gap = 0;
				end else begin
					if ($urandom_range(7) == 0)
						burst_left = $urandom_range(40, 10);
					gap = $urandom_range(9);
				end
				if (n == PHASE_ITEMS / 2)
					drain();
				issue(r, gap);
			end
		end

		drain();
		repeat (40) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/ffara_pkg.sv
rtl/ffara_ram.sv
rtl/ffara_rem.sv
rtl/ffara_dp.sv
rtl/ffara_ctrl.sv
rtl/first_fit_aligned_region_allocator.sv
tb/region_alloc_checker.sv
tb/tb.sv
